### hw/rtl/qtt_pkg.sv
// Shared types, constants and character-class functions for the query text tokenizer.
package qtt_pkg;

  // Span positions saturate at this offset
  localparam int unsigned POS_W   = 16;
  localparam logic [POS_W-1:0] MAX_TEXT_LEN = 16'hFFFF;

  // Tokens one text byte or end marker can produce
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // Result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Held operator codes; in dot-pending mode bit 0 means the position moved past the dot
  localparam logic [1:0] OP_GT        = 2'd0;
  localparam logic [1:0] OP_LT        = 2'd1;
  localparam logic [1:0] OP_BANG      = 2'd2;
  localparam logic [1:0] OP_EQ        = 2'd3;
  localparam logic [1:0] DOT_ADVANCED = 2'd1;

  typedef enum logic [4:0] {
    KIND_END    = 5'd0,
    KIND_ERROR  = 5'd1,
    KIND_NUMBER = 5'd2,
    KIND_STRING = 5'd3,
    KIND_IDENT  = 5'd4,
    KIND_COLON  = 5'd5,
    KIND_DOT    = 5'd6,
    KIND_LPAREN = 5'd7,
    KIND_RPAREN = 5'd8,
    KIND_COMMA  = 5'd9,
    KIND_AT     = 5'd10,
    KIND_EQ     = 5'd11,
    KIND_NOTEQ  = 5'd12,
    KIND_LT     = 5'd13,
    KIND_LTEQ   = 5'd14,
    KIND_GT     = 5'd15,
    KIND_GTEQ   = 5'd16,
    KIND_TILDE  = 5'd17,
    KIND_MINUS  = 5'd18,
    KIND_PLUS   = 5'd19
  } qtt_kind_t;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b0000001,
    MODE_OP    = 7'b0000010,
    MODE_INT   = 7'b0000100,
    MODE_DOT   = 7'b0001000,
    MODE_FRAC  = 7'b0010000,
    MODE_STR   = 7'b0100000,
    MODE_IDENT = 7'b1000000
  } qtt_mode_t;

  typedef struct packed {
    qtt_mode_t        mode;
    logic [1:0]       held_op;
    logic             quote_single;
    logic [POS_W-1:0] token_start;
    logic [POS_W-1:0] position;
  } qtt_state_t;

  typedef struct packed {
    qtt_kind_t        kind;
    logic [POS_W-1:0] span_begin;
    logic [POS_W-1:0] span_end;
    logic             last;
  } qtt_result_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] x);
    return (x == MAX_TEXT_LEN) ? MAX_TEXT_LEN : x + 1'b1;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    return (b == CH_GT) || (b == CH_LT) || (b == CH_BANG) || (b == CH_EQ);
  endfunction

  function automatic logic [1:0] op_code(input logic [7:0] b);
    logic [1:0] c;
    c = OP_EQ;
    if (b == CH_GT) c = OP_GT;
    else if (b == CH_LT) c = OP_LT;
    else if (b == CH_BANG) c = OP_BANG;
    return c;
  endfunction

  // Lone operator; a lone '!' is an error
  function automatic qtt_kind_t op_single_kind(input logic [1:0] c);
    qtt_kind_t k;
    unique case (c)
      OP_GT:   k = KIND_GT;
      OP_LT:   k = KIND_LT;
      OP_BANG: k = KIND_ERROR;
      default: k = KIND_EQ;
    endcase
    return k;
  endfunction

  function automatic qtt_kind_t op_double_kind(input logic [1:0] c);
    qtt_kind_t k;
    unique case (c)
      OP_GT:   k = KIND_GTEQ;
      OP_LT:   k = KIND_LTEQ;
      OP_BANG: k = KIND_NOTEQ;
      default: k = KIND_EQ;
    endcase
    return k;
  endfunction

  // One-character punctuation; KIND_END means none
  function automatic qtt_kind_t single_kind(input logic [7:0] b);
    qtt_kind_t k;
    unique case (b)
      CH_COLON:  k = KIND_COLON;
      CH_DOT:    k = KIND_DOT;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_COMMA:  k = KIND_COMMA;
      CH_AT:     k = KIND_AT;
      CH_TILDE:  k = KIND_TILDE;
      CH_MINUS:  k = KIND_MINUS;
      CH_PLUS:   k = KIND_PLUS;
      default:   k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/query_text_tokenizer.sv
// Top level of the query text tokenizer: input register, lexer step, token queue.
// Each byte is held in the input register, then its tokens are stored in the queue.
// Throughput: one byte per cycle while the queue has room; results leave one per cycle
//   while out_ready is high, so a byte making two or three tokens takes one transfer
//   each; input is held only when fewer than three of the 8 queue entries are free.
// Reset (rst_n low, synchronous): lexer idle at offset 0, input register and queue empty.
module query_text_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_span_begin,
  output logic [15:0] out_span_end,
  output logic        out_last_of_run
);
  import qtt_pkg::*;

  logic             hold_vld_r;
  logic [7:0]       hold_byte_r;
  logic             hold_end_r;
  qtt_state_t       lex_r, lex_nxt;
  qtt_result_t      step_res [MAX_RESULTS];
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] push_cnt;
  logic             room;
  logic             step_go;
  qtt_result_t      head;

  assign step_go  = hold_vld_r && room;
  assign in_ready = !hold_vld_r || step_go;
  assign push_cnt = step_go ? step_cnt : '0;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_vld_r <= 1'b1;
    end else if (step_go) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_text_byte;
      hold_end_r  <= in_end_of_text;
    end
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r <= '{mode: MODE_IDLE, held_op: '0, quote_single: 1'b0,
                 token_start: '0, position: '0};
    end else if (step_go) begin
      lex_r <= lex_nxt;
    end
  end

  qtt_lex_step u_step (
    .cur         (lex_r),
    .text_byte   (hold_byte_r),
    .end_of_text (hold_end_r),
    .nxt         (lex_nxt),
    .res         (step_res),
    .res_cnt     (step_cnt)
  );

  qtt_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_data (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_token_kind  = head.kind;
  assign out_span_begin  = head.span_begin;
  assign out_span_end    = head.span_end;
  assign out_last_of_run = head.last;

endmodule

### hw/rtl/qtt_lex_step.sv
// Lexer transition: next state and up to three tokens for one byte or end marker.
module qtt_lex_step (
  input  qtt_pkg::qtt_state_t  cur,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output qtt_pkg::qtt_state_t  nxt,
  output qtt_pkg::qtt_result_t res [qtt_pkg::MAX_RESULTS],
  output logic [qtt_pkg::CNT_W-1:0] res_cnt
);
  import qtt_pkg::*;

  logic [POS_W-1:0] p;
  logic [POS_W-1:0] nx;
  logic [POS_W-1:0] dot_pos;
  qtt_kind_t        sk;

  assign p       = cur.position;
  assign nx      = sat_inc(p);
  assign dot_pos = (cur.held_op[0]) ? p - 1'b1 : p;
  assign sk      = single_kind(text_byte);

  always_comb begin
    logic [CNT_W-1:0] n;
    logic             again;
    n     = '0;
    again = 1'b0;
    nxt   = cur;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '{kind: KIND_END, span_begin: '0, span_end: '0, last: 1'b0};
    end

    if (end_of_text) begin
      // Close the open token, then the end token
      unique case (cur.mode)
        MODE_OP: begin
          res[n] = '{op_single_kind(cur.held_op), cur.token_start,
                     sat_inc(cur.token_start), 1'b0};
          n = n + 1'b1;
        end
        MODE_INT, MODE_FRAC: begin
          res[n] = '{KIND_NUMBER, cur.token_start, p, 1'b0};
          n = n + 1'b1;
        end
        MODE_DOT: begin
          res[n] = '{KIND_NUMBER, cur.token_start, dot_pos, 1'b0};
          n = n + 1'b1;
          res[n] = '{KIND_DOT, dot_pos, sat_inc(dot_pos), 1'b0};
          n = n + 1'b1;
        end
        MODE_STR: begin
          res[n] = '{KIND_ERROR, cur.token_start, p, 1'b0};
          n = n + 1'b1;
        end
        MODE_IDENT: begin
          res[n] = '{KIND_IDENT, cur.token_start, p, 1'b0};
          n = n + 1'b1;
        end
        default: ;
      endcase
      res[n] = '{KIND_END, p, p, 1'b0};
      n = n + 1'b1;
      nxt = '{mode: MODE_IDLE, held_op: '0, quote_single: 1'b0,
              token_start: '0, position: '0};
    end else begin
      // Extend or finish the open token
      unique case (cur.mode)
        MODE_OP: begin
          if (text_byte == CH_EQ) begin
            res[n] = '{op_double_kind(cur.held_op), cur.token_start, nx, 1'b0};
            n = n + 1'b1;
          end else begin
            res[n] = '{op_single_kind(cur.held_op), cur.token_start,
                       sat_inc(cur.token_start), 1'b0};
            n = n + 1'b1;
            again = 1'b1;
          end
          nxt.mode    = MODE_IDLE;
          nxt.held_op = '0;
        end
        MODE_INT: begin
          if (text_byte == CH_DOT) begin
            nxt.mode    = MODE_DOT;
            nxt.held_op = (p != MAX_TEXT_LEN) ? DOT_ADVANCED : 2'd0;
          end else if (!is_digit(text_byte)) begin
            res[n] = '{KIND_NUMBER, cur.token_start, p, 1'b0};
            n = n + 1'b1;
            nxt.mode = MODE_IDLE;
            again    = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit(text_byte)) begin
            nxt.mode = MODE_FRAC;
          end else begin
            // Dot not followed by a digit: number ends before it
            res[n] = '{KIND_NUMBER, cur.token_start, dot_pos, 1'b0};
            n = n + 1'b1;
            res[n] = '{KIND_DOT, dot_pos, sat_inc(dot_pos), 1'b0};
            n = n + 1'b1;
            nxt.mode = MODE_IDLE;
            again    = 1'b1;
          end
          nxt.held_op = '0;
        end
        MODE_FRAC: begin
          if (!is_digit(text_byte)) begin
            res[n] = '{KIND_NUMBER, cur.token_start, p, 1'b0};
            n = n + 1'b1;
            nxt.mode = MODE_IDLE;
            again    = 1'b1;
          end
        end
        MODE_STR: begin
          if (text_byte == (cur.quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
            res[n] = '{KIND_STRING, sat_inc(cur.token_start), p, 1'b0};
            n = n + 1'b1;
            nxt.mode         = MODE_IDLE;
            nxt.quote_single = 1'b0;
          end
        end
        MODE_IDENT: begin
          if (!(is_alpha(text_byte) || is_digit(text_byte) || text_byte == CH_UNDER)) begin
            res[n] = '{KIND_IDENT, cur.token_start, p, 1'b0};
            n = n + 1'b1;
            nxt.mode = MODE_IDLE;
            again    = 1'b1;
          end
        end
        MODE_IDLE: begin
          again = 1'b1;
        end
        default: begin
          nxt.mode = MODE_IDLE;
          again    = 1'b1;
        end
      endcase

      // Byte starts a new token from idle
      if (again && !is_space(text_byte)) begin
        if (is_op(text_byte)) begin
          nxt.mode        = MODE_OP;
          nxt.held_op     = op_code(text_byte);
          nxt.token_start = p;
        end else if (sk != KIND_END) begin
          res[n] = '{sk, p, nx, 1'b0};
          n = n + 1'b1;
        end else if (is_digit(text_byte)) begin
          nxt.mode        = MODE_INT;
          nxt.token_start = p;
        end else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
          nxt.mode         = MODE_STR;
          nxt.quote_single = (text_byte == CH_SQUOTE);
          nxt.token_start  = p;
        end else if (is_alpha(text_byte) || text_byte == CH_UNDER) begin
          nxt.mode        = MODE_IDENT;
          nxt.token_start = p;
        end else begin
          res[n] = '{KIND_ERROR, p, nx, 1'b0};
          n = n + 1'b1;
        end
      end
      nxt.position = nx;
    end

    // Flag the final token of this step
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = (CNT_W'(i + 1) == n);
    end
    res_cnt = n;
  end

endmodule

### hw/rtl/qtt_tok_fifo.sv
// Token queue: takes up to three tokens per cycle, delivers one per transfer.
module qtt_tok_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [qtt_pkg::CNT_W-1:0] push_cnt,
  input  qtt_pkg::qtt_result_t      push_data [qtt_pkg::MAX_RESULTS],
  output logic                      room,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qtt_pkg::qtt_result_t      out_data
);
  import qtt_pkg::*;

  localparam int unsigned ROOM_LIMIT = FIFO_DEPTH - MAX_RESULTS;

  qtt_result_t           mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= FIFO_CNT_W'(ROOM_LIMIT));

  // Pointer and fill count
  always_comb begin
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
    count_nxt  = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes, in token order
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (CNT_W'(i) < push_cnt) begin
        mem[wr_ptr_r + FIFO_PTR_W'(i)] <= push_data[i];
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("token queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != '0) |-> room)
    else $error("tokens pushed without room");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && push_cnt != '0) |=> out_valid)
    else $error("pushed token not presented");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt == '0 && !pop) |=> $stable(count_r))
    else $error("fill count moved without transfer");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for query_text_tokenizer: byte stream in, predicted token stream out.
`timescale 1ns / 1ps

module testbench;
  import qtt_pkg::*;

  // One queued input transfer
  typedef struct {
    logic [7:0]  text;
    logic        eot;
    int unsigned phase;
  } text_item_t;

  // One predicted token
  typedef struct {
    qtt_kind_t   kind;
    logic [15:0] span_lo;
    logic [15:0] span_hi;
    logic        last;
  } token_t;

  typedef enum {CC_SPACE, CC_DIGIT, CC_WORD, CC_QUOTE, CC_OTHER} char_cls_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_token_kind;
  logic [15:0] out_span_begin;
  logic [15:0] out_span_end;
  logic        out_last_of_run;

  query_text_tokenizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_span_begin (out_span_begin),
    .out_span_end   (out_span_end),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle percentages per phase: sender, then receiver
  int unsigned send_idle [3] = '{6, 51, 0};
  int unsigned recv_idle [3] = '{51, 6, 0};

  text_item_t  byte_stream [$];
  token_t      expected_tokens [$];
  token_t      step_tokens [$];
  int unsigned fill_phase = 0;
  int unsigned cur_phase = 0;
  logic        byte_taken = 1'b0;
  int unsigned bytes_accepted = 0;
  int unsigned texts_ended = 0;
  int unsigned tokens_checked = 0;
  int unsigned fail_count = 0;
  int unsigned stall_left = 0;
  int unsigned stalls_done = 0;

  string word_start = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digit_chars = "0123456789";
  string blank_chars = " \t\n\013\014\015";

  // Lexer state mirror
  qtt_mode_t   lex_state = MODE_IDLE;
  logic [1:0]  held_op = '0;
  logic        quote_single = 1'b0;
  logic [15:0] tok_start = '0;
  logic [15:0] cur_pos = '0;

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] bump(input logic [15:0] p);
    return (&p) ? p : p + 16'd1;
  endfunction

  function automatic char_cls_t classify(input logic [7:0] b);
    if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) return CC_SPACE;
    if (b >= "0" && b <= "9") return CC_DIGIT;
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER) return CC_WORD;
    if (b == CH_SQUOTE || b == CH_DQUOTE) return CC_QUOTE;
    return CC_OTHER;
  endfunction

  // Held comparison char, alone or followed by '='
  function automatic qtt_kind_t op_kind(input logic [1:0] code, input logic paired);
    case (code)
      OP_GT:   return paired ? KIND_GTEQ : KIND_GT;
      OP_LT:   return paired ? KIND_LTEQ : KIND_LT;
      OP_BANG: return paired ? KIND_NOTEQ : KIND_ERROR;
      default: return KIND_EQ;
    endcase
  endfunction

  task automatic note_token(input qtt_kind_t k, input logic [15:0] lo, input logic [15:0] hi);
    token_t t;
    t.kind = k;
    t.span_lo = lo;
    t.span_hi = hi;
    t.last = 1'b0;
    if (step_tokens.size() < MAX_RESULTS) step_tokens.insert(step_tokens.size(), t);
  endtask

  // Byte seen from the idle state
  task automatic begin_token(input logic [7:0] b, input logic [15:0] p, input logic [15:0] nx);
    qtt_kind_t  pk;
    logic       is_cmp;
    logic [1:0] code;
    pk = KIND_END;
    is_cmp = 1'b1;
    code = OP_EQ;
    case (b)
      CH_GT:   code = OP_GT;
      CH_LT:   code = OP_LT;
      CH_BANG: code = OP_BANG;
      CH_EQ:   code = OP_EQ;
      default: is_cmp = 1'b0;
    endcase
    case (b)
      CH_COLON:  pk = KIND_COLON;
      CH_DOT:    pk = KIND_DOT;
      CH_LPAREN: pk = KIND_LPAREN;
      CH_RPAREN: pk = KIND_RPAREN;
      CH_COMMA:  pk = KIND_COMMA;
      CH_AT:     pk = KIND_AT;
      CH_TILDE:  pk = KIND_TILDE;
      CH_MINUS:  pk = KIND_MINUS;
      CH_PLUS:   pk = KIND_PLUS;
      default:   pk = KIND_END;
    endcase
    if (is_cmp) begin
      lex_state = MODE_OP;
      held_op = code;
      tok_start = p;
    end else if (pk != KIND_END) begin
      note_token(pk, p, nx);
    end else begin
      case (classify(b))
        CC_SPACE: ;
        CC_DIGIT: begin
          lex_state = MODE_INT;
          tok_start = p;
        end
        CC_QUOTE: begin
          lex_state = MODE_STR;
          quote_single = (b == CH_SQUOTE);
          tok_start = p;
        end
        CC_WORD: begin
          lex_state = MODE_IDENT;
          tok_start = p;
        end
        default: note_token(KIND_ERROR, p, nx);
      endcase
    end
  endtask

  // Advance the mirror by one accepted transfer and queue the tokens it makes
  task automatic lex_byte(input logic [7:0] b, input logic eot);
    logic [15:0] p, nx, dp;
    logic        again;
    p = cur_pos;
    nx = bump(p);
    dp = held_op[0] ? p - 16'd1 : p;
    again = 1'b0;
    step_tokens.delete();
    if (eot) begin
      // Close whatever is open, then the end token; next text restarts at offset 0
      case (lex_state)
        MODE_OP:    note_token(op_kind(held_op, 1'b0), tok_start, bump(tok_start));
        MODE_INT,
        MODE_FRAC:  note_token(KIND_NUMBER, tok_start, p);
        MODE_DOT: begin
          note_token(KIND_NUMBER, tok_start, dp);
          note_token(KIND_DOT, dp, bump(dp));
        end
        MODE_STR:   note_token(KIND_ERROR, tok_start, p);
        MODE_IDENT: note_token(KIND_IDENT, tok_start, p);
        default: ;
      endcase
      note_token(KIND_END, p, p);
      lex_state = MODE_IDLE;
      held_op = '0;
      quote_single = 1'b0;
      tok_start = '0;
      cur_pos = '0;
    end else begin
      case (lex_state)
        MODE_OP: begin
          if (b == CH_EQ) begin
            note_token(op_kind(held_op, 1'b1), tok_start, nx);
          end else begin
            note_token(op_kind(held_op, 1'b0), tok_start, bump(tok_start));
            again = 1'b1;
          end
          lex_state = MODE_IDLE;
          held_op = '0;
        end
        MODE_INT: begin
          if (b == CH_DOT) begin
            lex_state = MODE_DOT;
            held_op = (p != MAX_TEXT_LEN) ? DOT_ADVANCED : '0;
          end else if (classify(b) != CC_DIGIT) begin
            note_token(KIND_NUMBER, tok_start, p);
            lex_state = MODE_IDLE;
            again = 1'b1;
          end
        end
        MODE_DOT: begin
          // The dot only belongs to the number when a digit follows
          if (classify(b) == CC_DIGIT) begin
            lex_state = MODE_FRAC;
          end else begin
            note_token(KIND_NUMBER, tok_start, dp);
            note_token(KIND_DOT, dp, bump(dp));
            lex_state = MODE_IDLE;
            again = 1'b1;
          end
          held_op = '0;
        end
        MODE_FRAC: begin
          if (classify(b) != CC_DIGIT) begin
            note_token(KIND_NUMBER, tok_start, p);
            lex_state = MODE_IDLE;
            again = 1'b1;
          end
        end
        MODE_STR: begin
          if (b == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
            note_token(KIND_STRING, bump(tok_start), p);
            lex_state = MODE_IDLE;
            quote_single = 1'b0;
          end
        end
        MODE_IDENT: begin
          if (classify(b) != CC_WORD && classify(b) != CC_DIGIT) begin
            note_token(KIND_IDENT, tok_start, p);
            lex_state = MODE_IDLE;
            again = 1'b1;
          end
        end
        default: begin
          lex_state = MODE_IDLE;
          again = 1'b1;
        end
      endcase
      if (again) begin_token(b, p, nx);
      cur_pos = nx;
    end
    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic add_byte(input logic [7:0] b);
    text_item_t it;
    it.text = b;
    it.eot = 1'b0;
    it.phase = fill_phase;
    byte_stream.insert(byte_stream.size(), it);
  endtask

  // End marker; the byte lane carries junk
  task automatic add_end();
    text_item_t it;
    it.text = 8'($urandom_range(255));
    it.eot = 1'b1;
    it.phase = fill_phase;
    byte_stream.insert(byte_stream.size(), it);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Mostly well-formed tokens with random content, some noise and early ends
  task automatic add_random_token();
    int unsigned sel;
    logic [7:0]  q, c;
    sel = $urandom_range(11);
    case (sel)
      0, 1: begin
        add_byte(pick(word_start));
        repeat ($urandom_range(5)) add_byte(pick({word_start, digit_chars}));
      end
      2: repeat ($urandom_range(1, 4)) add_byte(pick(digit_chars));
      3, 4: begin
        // fraction, or a dot left hanging for the next token
        repeat ($urandom_range(1, 3)) add_byte(pick(digit_chars));
        add_byte(CH_DOT);
        if (sel == 3) repeat ($urandom_range(1, 3)) add_byte(pick(digit_chars));
      end
      5, 6: add_byte(pick(":.(),@~-+"));
      7: begin
        add_byte(pick("><!="));
        if ($urandom_range(1)) add_byte(CH_EQ);
      end
      8: begin
        q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
        add_byte(q);
        repeat ($urandom_range(5)) begin
          c = 8'($urandom_range(255));
          if (c == q) c = CH_SPACE;
          add_byte(c);
        end
        if ($urandom_range(9) != 0) add_byte(q);
      end
      9: repeat ($urandom_range(1, 3)) add_byte(pick(blank_chars));
      10: add_byte(8'($urandom_range(255)));
      default: add_end();
    endcase
    if ($urandom_range(1)) add_byte(pick(blank_chars));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: next queued byte at the falling edge once the previous one transferred
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    text_item_t nxt;
    if (rst_n && (!in_valid || byte_taken)) begin
      if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle[byte_stream[0].phase]) begin
        nxt = byte_stream.pop_front();
        in_valid <= 1'b1;
        in_text_byte <= nxt.text;
        in_end_of_text <= nxt.eot;
        cur_phase <= nxt.phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that back the block up
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stalls_done < 2 && bytes_accepted >= 40 + 160 * stalls_done) begin
        stall_left = 89;
        stalls_done++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle[cur_phase]);
      end
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : monitor
    token_t want;
    byte_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lex_byte(in_text_byte, in_end_of_text);
        bytes_accepted++;
        if (in_end_of_text) texts_ended++;
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d span %0d..%0d", out_token_kind,
                 out_span_begin, out_span_end);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          if (out_token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, out_token_kind);
            fail_count++;
          end
          if (out_span_begin !== want.span_lo) begin
            $error("span_begin: expected %0d, got %0d", want.span_lo, out_span_begin);
            fail_count++;
          end
          if (out_span_end !== want.span_hi) begin
            $error("span_end: expected %0d, got %0d", want.span_hi, out_span_end);
            fail_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    fill_phase = 0;
    // Paired comparisons, "==" after "!=", lone '!' closed by the end marker
    add_str(">=<=!===!");
    add_end();
    // Number with a bare dot, then an unterminated string holding byte 0xFF
    add_str("9.x\"");
    add_byte(8'hFF);
    add_end();
    // Zero byte is an error; single-quoted string around a double quote; punctuation
    add_byte(8'h00);
    add_str("'\"':.(),@~-+");
    add_end();

    while (byte_stream.size() < 100) add_random_token();
    fill_phase = 1;
    while (byte_stream.size() < 170) add_random_token();
    fill_phase = 2;
    while (byte_stream.size() < 245) add_random_token();
    add_end();

    // fresh text restarts at offset 0
    add_str("(z");
    add_end();

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (byte_stream.size() == 0 && !in_valid);
    wait (expected_tokens.size() == 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d bytes in %0d texts across three stall mixes and two long holds;",
             bytes_accepted, texts_ended);
    $display("%0d tokens compared field by field.", tokens_checked);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #24_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### query_text_tokenizer.f
hw/rtl/qtt_pkg.sv
hw/rtl/qtt_lex_step.sv
hw/rtl/qtt_tok_fifo.sv
hw/rtl/query_text_tokenizer.sv
dv/testbench.sv
